FILE: design/cia_regs_pkg.sv
// ----------------------------------------------------------------------------
// cia_regs_pkg
// Codes, field masks and BCD helpers for the interface adapter register file.
// ----------------------------------------------------------------------------
package cia_regs_pkg;

  localparam int MATRIX_ROWS = 8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_KEY   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    REG_PRA    = 4'h0,
    REG_PRB    = 4'h1,
    REG_DDRA   = 4'h2,
    REG_DDRB   = 4'h3,
    REG_TA_LO  = 4'h4,
    REG_TA_HI  = 4'h5,
    REG_TB_LO  = 4'h6,
    REG_TB_HI  = 4'h7,
    REG_TOD_TN = 4'h8,
    REG_TOD_SC = 4'h9,
    REG_TOD_MN = 4'ha,
    REG_TOD_HR = 4'hb,
    REG_SDR    = 4'hc,
    REG_ICR    = 4'hd,
    REG_CRA    = 4'he,
    REG_CRB    = 4'hf
  } reg_addr_t;

  localparam logic [7:0] TOD_MASK_TN = 8'h0f;
  localparam logic [7:0] TOD_MASK_SC = 8'h7f;
  localparam logic [7:0] TOD_MASK_MN = 8'h7f;
  localparam logic [7:0] TOD_MASK_HR = 8'h9f;
  localparam logic [7:0] CTRL_KEEP   = 8'hef;
  localparam logic [7:0] FLAG_ALARM  = 8'h04;
  localparam logic [7:0] FLAG_SERIAL = 8'h08;
  localparam logic [4:0] ICR_EN_MASK = 5'h1f;

  localparam int CTRL_START_BIT = 0;
  localparam int CTRL_LOAD_BIT  = 4;
  localparam int CTRL_ALARM_BIT = 7;
  localparam int CTRL_50HZ_BIT  = 7;
  localparam int ICR_SET_BIT    = 7;
  localparam int IRQ_BIT        = 7;
  localparam int PEN_BIT        = 4;

  localparam logic [2:0] TOD_DIV_50HZ = 3'd4;
  localparam logic [2:0] TOD_DIV_60HZ = 3'd5;

  typedef struct packed {
    logic       carry;
    logic [6:0] value;
  } sixty_t;

  // BCD increment of a seconds or minutes field
  function automatic sixty_t bump_sixty(input logic [6:0] f);
    logic [4:0] lo;
    logic [3:0] hi;
    sixty_t     res;
    lo = {1'b0, f[3:0]} + 5'd1;
    hi = {1'b0, f[6:4]};
    if (lo > 5'd9) begin
      lo = '0;
      hi = hi + 4'd1;
    end
    if (hi > 4'd5) begin
      res.carry = 1'b1;
      res.value = '0;
    end else begin
      res.carry = 1'b0;
      res.value = {hi[2:0], lo[3:0]};
    end
    return res;
  endfunction

  // 12-hour BCD increment; PM flag toggles on the step from 11 to 12
  function automatic logic [7:0] bump_hour(input logic [7:0] hr);
    logic       pm;
    logic [4:0] h;
    logic [4:0] lo;
    logic [1:0] hi;
    logic [5:0] n;
    logic [7:0] res;
    pm = hr[7];
    h  = hr[4:0];
    if (h == 5'h12) begin
      res = {pm, 7'h01};
    end else begin
      lo = {1'b0, h[3:0]} + 5'd1;
      hi = {1'b0, h[4]};
      if (lo > 5'd9) begin
        lo = '0;
        hi = hi + 2'd1;
      end
      n = {hi, lo[3:0]};
      if (n == 6'h12) begin
        res = {~pm, 7'h12};
      end else if (n > 6'h12) begin
        res = {pm, 7'h01};
      end else begin
        res = {pm, 1'b0, n};
      end
    end
    return res;
  endfunction

endpackage

FILE: design/complex_interface_adapter_regs.sv
// ----------------------------------------------------------------------------
// complex_interface_adapter_regs
// Register file of an interface adapter: ports, directions, timer latches,
// control bytes, interrupt flags and mask, BCD time-of-day clock with alarm,
// and an 8x8 keyboard matrix scan on port reads.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | opcode, reg_addr, write_data, joy_one,
//           |                       | joy_two, row_index, key_row_bits,
//           |                       | rev_row_bits
//  out      | out_valid / out_ready | read_data, irq_line, lightpen_pulse
//
// One word per cycle sustained while out_ready stays high; a word lands in the
// input register when accepted, and one pass of the register file logic then
// puts its result in the result register, which drives out_valid.
// Reset puts the register file at its power-up values and empties both stages.
// A stalled result holds the pipe; the input register takes a word while
// the result register waits only if it is empty.
module complex_interface_adapter_regs (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_opcode,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_joy_one,
  input  logic [7:0] in_joy_two,
  input  logic [2:0] in_row_index,
  input  logic [7:0] in_key_row_bits,
  input  logic [7:0] in_rev_row_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_irq_line,
  output logic       out_lightpen_pulse
);
  import cia_regs_pkg::*;

  // input register
  logic       s1_valid_r;
  op_t        s1_op_r;
  reg_addr_t  s1_addr_r;
  logic [7:0] s1_wdata_r;
  logic [7:0] s1_joy1_r;
  logic [7:0] s1_joy2_r;
  logic [2:0] s1_row_r;
  logic [7:0] s1_key_r;
  logic [7:0] s1_rev_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_data_r;
  logic       out_irq_r;
  logic       out_pen_r;

  // register file state
  logic [7:0]  port_a_r, port_a_nxt;
  logic [7:0]  port_b_r, port_b_nxt;
  logic [7:0]  dir_a_r, dir_a_nxt;
  logic [7:0]  dir_b_r, dir_b_nxt;
  logic [15:0] timer_a_r, timer_a_nxt;
  logic [15:0] timer_b_r, timer_b_nxt;
  logic [15:0] latch_a_r, latch_a_nxt;
  logic [15:0] latch_b_r, latch_b_nxt;
  logic [7:0]  ctrl_a_r, ctrl_a_nxt;
  logic [7:0]  ctrl_b_r, ctrl_b_nxt;
  logic [3:0]  tod_tn_r, tod_tn_nxt;
  logic [6:0]  tod_sc_r, tod_sc_nxt;
  logic [6:0]  tod_mn_r, tod_mn_nxt;
  logic [7:0]  tod_hr_r, tod_hr_nxt;
  logic [3:0]  alm_tn_r, alm_tn_nxt;
  logic [6:0]  alm_sc_r, alm_sc_nxt;
  logic [6:0]  alm_mn_r, alm_mn_nxt;
  logic [7:0]  alm_hr_r, alm_hr_nxt;
  logic [7:0]  serial_r, serial_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [4:0]  enable_r, enable_nxt;
  logic [2:0]  tod_div_r, tod_div_nxt;
  logic        tod_stop_r, tod_stop_nxt;
  logic        pen_bit_r, pen_bit_nxt;
  logic [7:0]  key_rows_r [MATRIX_ROWS];
  logic [7:0]  rev_rows_r [MATRIX_ROWS];

  logic       advance;
  logic       in_accept;
  logic       process;
  logic [7:0] data_nxt;
  logic       pen_nxt;
  logic [7:0] scan_a;
  logic [7:0] scan_b;
  logic [7:0] tst_a;
  logic [7:0] tst_b;

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign in_accept = in_valid && in_ready;
  assign process   = s1_valid_r && advance;

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_data_r;
  assign out_irq_line       = out_irq_r;
  assign out_lightpen_pulse = out_pen_r;

  // keyboard matrix scan, both directions
  always_comb begin
    tst_a  = (port_b_r | ~dir_b_r) & s1_joy1_r;
    scan_a = port_a_r | ~dir_a_r;
    tst_b  = (port_a_r | ~dir_a_r) & s1_joy2_r;
    scan_b = ~dir_b_r;
    for (int i = 0; i < MATRIX_ROWS; i++) begin
      if (!tst_a[i]) scan_a = scan_a & rev_rows_r[i];
      if (!tst_b[i]) scan_b = scan_b & key_rows_r[i];
    end
  end

  always_comb begin
    sixty_t sc_step;
    sixty_t mn_step;
    logic   alarm_chk;
    logic   pen_now;
    port_a_nxt   = port_a_r;
    port_b_nxt   = port_b_r;
    dir_a_nxt    = dir_a_r;
    dir_b_nxt    = dir_b_r;
    timer_a_nxt  = timer_a_r;
    timer_b_nxt  = timer_b_r;
    latch_a_nxt  = latch_a_r;
    latch_b_nxt  = latch_b_r;
    ctrl_a_nxt   = ctrl_a_r;
    ctrl_b_nxt   = ctrl_b_r;
    tod_tn_nxt   = tod_tn_r;
    tod_sc_nxt   = tod_sc_r;
    tod_mn_nxt   = tod_mn_r;
    tod_hr_nxt   = tod_hr_r;
    alm_tn_nxt   = alm_tn_r;
    alm_sc_nxt   = alm_sc_r;
    alm_mn_nxt   = alm_mn_r;
    alm_hr_nxt   = alm_hr_r;
    serial_nxt   = serial_r;
    flags_nxt    = flags_r;
    enable_nxt   = enable_r;
    tod_div_nxt  = tod_div_r;
    tod_stop_nxt = tod_stop_r;
    pen_bit_nxt  = pen_bit_r;
    data_nxt     = '0;
    pen_nxt      = 1'b0;
    alarm_chk    = 1'b0;
    sc_step      = bump_sixty(tod_sc_r);
    mn_step      = bump_sixty(tod_mn_r);
    pen_now      = 1'b0;

    case (s1_op_r)
      OP_READ: begin
        case (s1_addr_r)
          REG_PRA:    data_nxt = scan_a & s1_joy2_r;
          REG_PRB:    data_nxt = (scan_b | (port_b_r & dir_b_r)) & s1_joy1_r;
          REG_DDRA:   data_nxt = dir_a_r;
          REG_DDRB:   data_nxt = dir_b_r;
          REG_TA_LO:  data_nxt = timer_a_r[7:0];
          REG_TA_HI:  data_nxt = timer_a_r[15:8];
          REG_TB_LO:  data_nxt = timer_b_r[7:0];
          REG_TB_HI:  data_nxt = timer_b_r[15:8];
          REG_TOD_TN: data_nxt = {4'h0, tod_tn_r};
          REG_TOD_SC: data_nxt = {1'b0, tod_sc_r};
          REG_TOD_MN: data_nxt = {1'b0, tod_mn_r};
          REG_TOD_HR: data_nxt = tod_hr_r;
          REG_SDR:    data_nxt = serial_r;
          REG_ICR: begin
            data_nxt  = flags_r;
            flags_nxt = '0;
          end
          REG_CRA:    data_nxt = ctrl_a_r;
          REG_CRB:    data_nxt = ctrl_b_r;
          default:    data_nxt = '0;
        endcase
      end
      OP_WRITE: begin
        case (s1_addr_r)
          REG_PRA:  port_a_nxt = s1_wdata_r;
          REG_PRB: begin
            port_b_nxt = s1_wdata_r;
            pen_now    = 1'b1;
          end
          REG_DDRA: dir_a_nxt = s1_wdata_r;
          REG_DDRB: begin
            dir_b_nxt = s1_wdata_r;
            pen_now   = 1'b1;
          end
          REG_TA_LO: latch_a_nxt = {latch_a_r[15:8], s1_wdata_r};
          REG_TA_HI: begin
            latch_a_nxt = {s1_wdata_r, latch_a_r[7:0]};
            if (!ctrl_a_r[CTRL_START_BIT]) timer_a_nxt = {s1_wdata_r, latch_a_r[7:0]};
          end
          REG_TB_LO: latch_b_nxt = {latch_b_r[15:8], s1_wdata_r};
          REG_TB_HI: begin
            latch_b_nxt = {s1_wdata_r, latch_b_r[7:0]};
            if (!ctrl_b_r[CTRL_START_BIT]) timer_b_nxt = {s1_wdata_r, latch_b_r[7:0]};
          end
          REG_TOD_TN: begin
            if (ctrl_b_r[CTRL_ALARM_BIT]) begin
              alm_tn_nxt = s1_wdata_r[3:0] & TOD_MASK_TN[3:0];
            end else begin
              tod_tn_nxt   = s1_wdata_r[3:0] & TOD_MASK_TN[3:0];
              tod_stop_nxt = 1'b0;
            end
            alarm_chk = 1'b1;
          end
          REG_TOD_SC: begin
            if (ctrl_b_r[CTRL_ALARM_BIT]) alm_sc_nxt = s1_wdata_r[6:0] & TOD_MASK_SC[6:0];
            else tod_sc_nxt = s1_wdata_r[6:0] & TOD_MASK_SC[6:0];
            alarm_chk = 1'b1;
          end
          REG_TOD_MN: begin
            if (ctrl_b_r[CTRL_ALARM_BIT]) alm_mn_nxt = s1_wdata_r[6:0] & TOD_MASK_MN[6:0];
            else tod_mn_nxt = s1_wdata_r[6:0] & TOD_MASK_MN[6:0];
            alarm_chk = 1'b1;
          end
          REG_TOD_HR: begin
            if (ctrl_b_r[CTRL_ALARM_BIT]) begin
              alm_hr_nxt = s1_wdata_r & TOD_MASK_HR;
            end else begin
              tod_hr_nxt   = s1_wdata_r & TOD_MASK_HR;
              tod_stop_nxt = 1'b1;
            end
            alarm_chk = 1'b1;
          end
          REG_SDR: begin
            serial_nxt = s1_wdata_r;
            flags_nxt  = flags_r | FLAG_SERIAL;
            if ((enable_r & FLAG_SERIAL[4:0]) != '0) flags_nxt[IRQ_BIT] = 1'b1;
          end
          REG_ICR: begin
            if (s1_wdata_r[ICR_SET_BIT]) begin
              enable_nxt = enable_r | (s1_wdata_r[4:0] & ICR_EN_MASK);
              if ((flags_r[4:0] & enable_nxt) != '0) flags_nxt[IRQ_BIT] = 1'b1;
            end else begin
              enable_nxt = enable_r & ~s1_wdata_r[4:0];
            end
          end
          REG_CRA: begin
            ctrl_a_nxt = s1_wdata_r & CTRL_KEEP;
            if (s1_wdata_r[CTRL_LOAD_BIT]) timer_a_nxt = latch_a_r;
          end
          REG_CRB: begin
            ctrl_b_nxt = s1_wdata_r & CTRL_KEEP;
            if (s1_wdata_r[CTRL_LOAD_BIT]) timer_b_nxt = latch_b_r;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (!tod_stop_r) begin
          if (tod_div_r != '0) begin
            tod_div_nxt = tod_div_r - 3'd1;
          end else begin
            tod_div_nxt = ctrl_a_r[CTRL_50HZ_BIT] ? TOD_DIV_50HZ : TOD_DIV_60HZ;
            // tenths wrap in four bits; 10 through 15 carry
            tod_tn_nxt  = tod_tn_r + 4'd1;
            if (tod_tn_nxt > 4'd9) begin
              tod_tn_nxt = '0;
              tod_sc_nxt = sc_step.value;
              if (sc_step.carry) begin
                tod_mn_nxt = mn_step.value;
                if (mn_step.carry) tod_hr_nxt = bump_hour(tod_hr_r);
              end
            end
            alarm_chk = 1'b1;
          end
        end
      end
      default: ;
    endcase

    if (alarm_chk && tod_tn_nxt == alm_tn_nxt && tod_sc_nxt == alm_sc_nxt &&
        tod_mn_nxt == alm_mn_nxt && tod_hr_nxt == alm_hr_nxt) begin
      flags_nxt = flags_nxt | FLAG_ALARM;
      if ((enable_nxt & FLAG_ALARM[4:0]) != '0) flags_nxt[IRQ_BIT] = 1'b1;
    end

    // light pen follows the port B bit 4 output level
    if (pen_now) begin
      pen_bit_nxt = port_b_nxt[PEN_BIT] | ~dir_b_nxt[PEN_BIT];
      pen_nxt     = pen_bit_nxt != pen_bit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      port_a_r    <= '0;
      port_b_r    <= '0;
      dir_a_r     <= '0;
      dir_b_r     <= '0;
      timer_a_r   <= '1;
      timer_b_r   <= '1;
      latch_a_r   <= '1;
      latch_b_r   <= '1;
      ctrl_a_r    <= '0;
      ctrl_b_r    <= '0;
      tod_tn_r    <= '0;
      tod_sc_r    <= '0;
      tod_mn_r    <= '0;
      tod_hr_r    <= 8'h01;
      alm_tn_r    <= '0;
      alm_sc_r    <= '0;
      alm_mn_r    <= '0;
      alm_hr_r    <= '0;
      serial_r    <= '0;
      flags_r     <= '0;
      enable_r    <= '0;
      tod_div_r   <= '0;
      tod_stop_r  <= 1'b1;
      pen_bit_r   <= 1'b1;
      for (int i = 0; i < MATRIX_ROWS; i++) begin
        key_rows_r[i] <= '1;
        rev_rows_r[i] <= '1;
      end
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) out_valid_r <= s1_valid_r;
      if (process) begin
        port_a_r   <= port_a_nxt;
        port_b_r   <= port_b_nxt;
        dir_a_r    <= dir_a_nxt;
        dir_b_r    <= dir_b_nxt;
        timer_a_r  <= timer_a_nxt;
        timer_b_r  <= timer_b_nxt;
        latch_a_r  <= latch_a_nxt;
        latch_b_r  <= latch_b_nxt;
        ctrl_a_r   <= ctrl_a_nxt;
        ctrl_b_r   <= ctrl_b_nxt;
        tod_tn_r   <= tod_tn_nxt;
        tod_sc_r   <= tod_sc_nxt;
        tod_mn_r   <= tod_mn_nxt;
        tod_hr_r   <= tod_hr_nxt;
        alm_tn_r   <= alm_tn_nxt;
        alm_sc_r   <= alm_sc_nxt;
        alm_mn_r   <= alm_mn_nxt;
        alm_hr_r   <= alm_hr_nxt;
        serial_r   <= serial_nxt;
        flags_r    <= flags_nxt;
        enable_r   <= enable_nxt;
        tod_div_r  <= tod_div_nxt;
        tod_stop_r <= tod_stop_nxt;
        pen_bit_r  <= pen_bit_nxt;
        if (s1_op_r == OP_KEY) begin
          key_rows_r[s1_row_r] <= s1_key_r;
          rev_rows_r[s1_row_r] <= s1_rev_r;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= op_t'(in_opcode);
      s1_addr_r  <= reg_addr_t'(in_reg_addr);
      s1_wdata_r <= in_write_data;
      s1_joy1_r  <= in_joy_one;
      s1_joy2_r  <= in_joy_two;
      s1_row_r   <= in_row_index;
      s1_key_r   <= in_key_row_bits;
      s1_rev_r   <= in_rev_row_bits;
    end
    if (process) begin
      out_data_r <= data_nxt;
      out_irq_r  <= flags_nxt[IRQ_BIT];
      out_pen_r  <= pen_nxt;
    end
  end

endmodule

FILE: sim/tb_complex_interface_adapter_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_interface_adapter_regs
// Self-checking bench for the interface adapter register file. Bus reads,
// bus writes, time-of-day ticks and keyboard updates go in through a
// valid/ready driver. A local register-file predictor computes each reply.
// A monitor checks every reply against the oldest prediction. Both sides
// idle in short random bursts, and the receiver holds off once for a long
// stretch.
// ----------------------------------------------------------------------------
module tb_complex_interface_adapter_regs;
  import cia_regs_pkg::*;

  localparam int RANDOM_WORDS   = 1800;
  localparam int QUIET_TAIL     = 150;
  localparam int LONG_HOLD_AT   = 600;
  localparam int LONG_HOLD_LEN  = 150;
  localparam int MAX_REPORTS    = 10;
  localparam logic [3:0][7:0] TOD_FIELD_MASK =
    {TOD_MASK_HR, TOD_MASK_MN, TOD_MASK_SC, TOD_MASK_TN};

  typedef struct packed {
    logic       drain;
    op_t        op;
    reg_addr_t  addr;
    logic [7:0] wdata;
    logic [7:0] joy1;
    logic [7:0] joy2;
    logic [2:0] row;
    logic [7:0] fwd_bits;
    logic [7:0] rev_bits;
  } bus_word_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq;
    logic       pen;
  } bus_reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_opcode = '0;
  logic [3:0] in_reg_addr = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_joy_one = '0;
  logic [7:0] in_joy_two = '0;
  logic [2:0] in_row_index = '0;
  logic [7:0] in_key_row_bits = '0;
  logic [7:0] in_rev_row_bits = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq_line;
  logic       out_lightpen_pulse;

  complex_interface_adapter_regs u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_reg_addr        (in_reg_addr),
    .in_write_data      (in_write_data),
    .in_joy_one         (in_joy_one),
    .in_joy_two         (in_joy_two),
    .in_row_index       (in_row_index),
    .in_key_row_bits    (in_key_row_bits),
    .in_rev_row_bits    (in_rev_row_bits),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data),
    .out_irq_line       (out_irq_line),
    .out_lightpen_pulse (out_lightpen_pulse)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Predicted register file, at power-up values
  logic [7:0]      pra_q = '0, prb_q = '0, ddra_q = '0, ddrb_q = '0;
  logic [15:0]     ta_cnt = '1, tb_cnt = '1, ta_latch = '1, tb_latch = '1;
  logic [7:0]      cra_q = '0, crb_q = '0, sdr_q = '0;
  logic [3:0][7:0] tod_now = 32'h0100_0000;
  logic [3:0][7:0] alarm_set = '0;
  logic [7:0]      icr_flags = '0;
  logic [4:0]      icr_mask = '0;
  logic [2:0]      tod_div = '0;
  logic            clock_held = 1'b1;
  logic            pen_prev = 1'b1;
  logic [7:0][7:0] key_fwd = '1;
  logic [7:0][7:0] key_rev = '1;

  bus_word_t  words_to_send [$];
  bus_reply_t replies_due [$];
  bus_word_t  cur_word;
  bus_reply_t want;
  logic       hold_for_drain = 1'b0;
  logic       quiet = 1'b0;
  logic       gap_armed = 1'b1;
  logic       stall_armed = 1'b1;
  int         gap_left;
  int         hold_left;
  int         ready_cycle;
  int         op_seen [4];
  int         replies_seen;
  int         fail_count;
  int         alarm_hits;
  int         hour_rolls;

  function automatic void raise_flag(input logic [7:0] bits);
    icr_flags = icr_flags | bits;
    if ((icr_mask & bits[4:0]) != '0) icr_flags[IRQ_BIT] = 1'b1;
  endfunction

  function automatic void check_alarm();
    if (tod_now == alarm_set) begin
      raise_flag(FLAG_ALARM);
      alarm_hits = alarm_hits + 1;
    end
  endfunction

  // {carry, field} after a BCD step of a seconds or minutes field
  function automatic logic [8:0] sixty_next(input logic [7:0] f);
    logic [4:0] lo;
    logic [3:0] hi;
    lo = {1'b0, f[3:0]} + 5'd1;
    hi = f[7:4];
    if (lo > 5'd9) begin
      lo = '0;
      hi = hi + 4'd1;
    end
    if (hi > 4'd5) return {1'b1, 8'h00};
    return {1'b0, hi, lo[3:0]};
  endfunction

  function automatic logic pen_moved();
    logic lvl;
    logic moved;
    lvl = prb_q[PEN_BIT] | ~ddrb_q[PEN_BIT];
    moved = (lvl != pen_prev);
    pen_prev = lvl;
    return moved;
  endfunction

  function automatic bus_reply_t next_bus_result(input bus_word_t w);
    bus_reply_t res;
    logic [7:0] v;
    logic [7:0] tst;
    logic [7:0] b;
    logic [8:0] carry_f;
    logic [7:0] pm;
    logic [7:0] h;
    logic [7:0] n;
    logic [4:0] lo;
    logic [4:0] hi;
    res = '0;
    case (w.op)
      OP_READ: begin
        case (w.addr)
          REG_PRA: begin
            v = pra_q | ~ddra_q;
            tst = (prb_q | ~ddrb_q) & w.joy1;
            for (int k = 0; k < MATRIX_ROWS; k++)
              if (!tst[k]) v = v & key_rev[k];
            res.rdata = v & w.joy2;
          end
          REG_PRB: begin
            v = ~ddrb_q;
            tst = (pra_q | ~ddra_q) & w.joy2;
            for (int k = 0; k < MATRIX_ROWS; k++)
              if (!tst[k]) v = v & key_fwd[k];
            res.rdata = (v | (prb_q & ddrb_q)) & w.joy1;
          end
          REG_DDRA:  res.rdata = ddra_q;
          REG_DDRB:  res.rdata = ddrb_q;
          REG_TA_LO: res.rdata = ta_cnt[7:0];
          REG_TA_HI: res.rdata = ta_cnt[15:8];
          REG_TB_LO: res.rdata = tb_cnt[7:0];
          REG_TB_HI: res.rdata = tb_cnt[15:8];
          REG_TOD_TN, REG_TOD_SC, REG_TOD_MN, REG_TOD_HR:
            res.rdata = tod_now[w.addr[1:0]];
          REG_SDR:   res.rdata = sdr_q;
          REG_ICR: begin
            res.rdata = icr_flags;
            icr_flags = '0;
          end
          REG_CRA:   res.rdata = cra_q;
          REG_CRB:   res.rdata = crb_q;
          default:   res.rdata = '0;
        endcase
      end
      OP_WRITE: begin
        b = w.wdata;
        case (w.addr)
          REG_PRA: pra_q = b;
          REG_PRB: begin
            prb_q = b;
            res.pen = pen_moved();
          end
          REG_DDRA: ddra_q = b;
          REG_DDRB: begin
            ddrb_q = b;
            res.pen = pen_moved();
          end
          REG_TA_LO: ta_latch[7:0] = b;
          REG_TA_HI: begin
            ta_latch[15:8] = b;
            if (!cra_q[CTRL_START_BIT]) ta_cnt = ta_latch;
          end
          REG_TB_LO: tb_latch[7:0] = b;
          REG_TB_HI: begin
            tb_latch[15:8] = b;
            if (!crb_q[CTRL_START_BIT]) tb_cnt = tb_latch;
          end
          REG_TOD_TN, REG_TOD_SC, REG_TOD_MN, REG_TOD_HR: begin
            b = b & TOD_FIELD_MASK[w.addr[1:0]];
            if (crb_q[CTRL_ALARM_BIT]) begin
              alarm_set[w.addr[1:0]] = b;
            end else begin
              tod_now[w.addr[1:0]] = b;
              if (w.addr == REG_TOD_TN) clock_held = 1'b0;
              if (w.addr == REG_TOD_HR) clock_held = 1'b1;
            end
            check_alarm();
          end
          REG_SDR: begin
            sdr_q = b;
            raise_flag(FLAG_SERIAL);
          end
          REG_ICR: begin
            if (b[ICR_SET_BIT]) begin
              icr_mask = icr_mask | (b[4:0] & ICR_EN_MASK);
              if ((icr_flags[4:0] & icr_mask) != '0) icr_flags[IRQ_BIT] = 1'b1;
            end else begin
              icr_mask = icr_mask & ~b[4:0];
            end
          end
          REG_CRA: begin
            cra_q = b & CTRL_KEEP;
            if (b[CTRL_LOAD_BIT]) ta_cnt = ta_latch;
          end
          REG_CRB: begin
            crb_q = b & CTRL_KEEP;
            if (b[CTRL_LOAD_BIT]) tb_cnt = tb_latch;
          end
          default: ;
        endcase
      end
      OP_TICK: begin
        if (!clock_held) begin
          if (tod_div != '0) begin
            tod_div = tod_div - 3'd1;
          end else begin
            tod_div = cra_q[CTRL_50HZ_BIT] ? TOD_DIV_50HZ : TOD_DIV_60HZ;
            tod_now[0] = {4'h0, tod_now[0][3:0] + 4'd1};
            if (tod_now[0] > 8'd9) begin
              tod_now[0] = '0;
              carry_f = sixty_next(tod_now[1]);
              tod_now[1] = carry_f[7:0];
              if (carry_f[8]) begin
                carry_f = sixty_next(tod_now[2]);
                tod_now[2] = carry_f[7:0];
                if (carry_f[8]) begin
                  // advance the 12-hour clock, flip PM on 11 -> 12
                  hour_rolls = hour_rolls + 1;
                  pm = tod_now[3] & 8'h80;
                  h = tod_now[3] & 8'h1f;
                  if (h == 8'h12) begin
                    tod_now[3] = pm | 8'h01;
                  end else begin
                    lo = {1'b0, h[3:0]} + 5'd1;
                    hi = {4'b0, h[4]};
                    if (lo > 5'd9) begin
                      lo = '0;
                      hi = hi + 5'd1;
                    end
                    n = {hi[3:0], lo[3:0]};
                    if (n == 8'h12)      tod_now[3] = (pm ^ 8'h80) | 8'h12;
                    else if (n > 8'h12)  tod_now[3] = pm | 8'h01;
                    else                 tod_now[3] = pm | n;
                  end
                end
              end
            end
            check_alarm();
          end
        end
      end
      OP_KEY: begin
        key_fwd[w.row] = w.fwd_bits;
        key_rev[w.row] = w.rev_bits;
      end
      default: ;
    endcase
    res.irq = icr_flags[IRQ_BIT];
    return res;
  endfunction

  // Stimulus building
  function automatic void enqueue_word(input op_t op, input reg_addr_t addr,
                                       input logic [7:0] wdata, input logic [7:0] j1,
                                       input logic [7:0] j2, input logic [2:0] row,
                                       input logic [7:0] fwd, input logic [7:0] rev);
    bus_word_t w;
    w.drain    = hold_for_drain;
    w.op       = op;
    w.addr     = addr;
    w.wdata    = wdata;
    w.joy1     = j1;
    w.joy2     = j2;
    w.row      = row;
    w.fwd_bits = fwd;
    w.rev_bits = rev;
    hold_for_drain = 1'b0;
    words_to_send.push_back(w);
  endfunction

  function automatic void put_read(input reg_addr_t addr, input logic [7:0] j1,
                                   input logic [7:0] j2);
    enqueue_word(OP_READ, addr, 8'($urandom), j1, j2, 3'($urandom),
                 8'($urandom), 8'($urandom));
  endfunction

  function automatic void put_write(input reg_addr_t addr, input logic [7:0] d);
    enqueue_word(OP_WRITE, addr, d, 8'($urandom), 8'($urandom), 3'($urandom),
                 8'($urandom), 8'($urandom));
  endfunction

  function automatic void put_tick();
    enqueue_word(OP_TICK, reg_addr_t'(4'($urandom)), 8'($urandom), 8'($urandom),
                 8'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic void put_key(input logic [2:0] row, input logic [7:0] fwd,
                                  input logic [7:0] rev);
    enqueue_word(OP_KEY, reg_addr_t'(4'($urandom)), 8'($urandom), 8'($urandom),
                 8'($urandom), row, fwd, rev);
  endfunction

  // Active-low lines: sometimes idle, often one or two pulled low, else random
  function automatic logic [7:0] rand_lines();
    case ($urandom_range(0, 3))
      0:       return 8'hff;
      1:       return ~(8'h01 << $urandom_range(0, 7));
      2:       return 8'($urandom);
      default: return ~(8'h01 << $urandom_range(0, 7)) & ~(8'h01 << $urandom_range(0, 7));
    endcase
  endfunction

  function automatic logic [7:0] rand_hour();
    case ($urandom_range(0, 5))
      0:       return 8'h11;
      1:       return 8'h91;
      2:       return 8'h12;
      3:       return 8'h92;
      4:       return {1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(1, 9))};
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] rand_bcd60();
    if ($urandom_range(0, 1) == 0) return 8'h59;
    return {1'b0, 3'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
  endfunction

  // Driver: one word on the bus at a time, held until taken
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      quiet <= (words_to_send.size() < QUIET_TAIL);
      if (in_valid && in_ready) begin
        replies_due.push_back(next_bus_result(cur_word));
        op_seen[cur_word.op] = op_seen[cur_word.op] + 1;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (words_to_send.size() == 0 ||
                     (words_to_send[0].drain && replies_due.size() != 0)) begin
          in_valid <= 1'b0;
        end else if (!quiet && gap_armed && $urandom_range(0, 4) == 0) begin
          gap_left = $urandom_range(0, 3);
          gap_armed = 1'b0;
          in_valid <= 1'b0;
        end else begin
          cur_word = words_to_send.pop_front();
          gap_armed = 1'b1;
          in_opcode       <= cur_word.op;
          in_reg_addr     <= cur_word.addr;
          in_write_data   <= cur_word.wdata;
          in_joy_one      <= cur_word.joy1;
          in_joy_two      <= cur_word.joy2;
          in_row_index    <= cur_word.row;
          in_key_row_bits <= cur_word.fwd_bits;
          in_rev_row_bits <= cur_word.rev_bits;
          in_valid        <= 1'b1;
        end
      end
    end
  end

  // Receiver: short random stalls, one long hold-off to back the pipe up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      ready_cycle = ready_cycle + 1;
      if (ready_cycle == LONG_HOLD_AT) hold_left = LONG_HOLD_LEN;
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet && stall_armed && $urandom_range(0, 4) == 0) begin
        hold_left = $urandom_range(0, 3);
        stall_armed = 1'b0;
        out_ready <= 1'b0;
      end else begin
        stall_armed = 1'b1;
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      replies_seen = replies_seen + 1;
      if (replies_due.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= MAX_REPORTS)
          $display("reply %0d with nothing predicted: rd=%02h irq=%0b pen=%0b",
                   replies_seen, out_read_data, out_irq_line, out_lightpen_pulse);
      end else begin
        want = replies_due.pop_front();
        if (out_read_data !== want.rdata || out_irq_line !== want.irq ||
            out_lightpen_pulse !== want.pen) begin
          fail_count = fail_count + 1;
          if (fail_count <= MAX_REPORTS)
            $display("reply %0d: want rd=%02h irq=%0b pen=%0b, got rd=%02h irq=%0b pen=%0b",
                     replies_seen, want.rdata, want.irq, want.pen,
                     out_read_data, out_irq_line, out_lightpen_pulse);
        end
      end
    end
  end

  initial begin
    logic [7:0] hr;
    logic [7:0] mn;
    logic [7:0] sc;
    logic [3:0] tn;
    logic [2:0] bit_sel;
    logic       mid_drain_done;
    int         k;
    mid_drain_done = 1'b0;

    // directed opening
    put_read(REG_ICR, 8'h00, 8'h00);
    put_read(REG_TOD_HR, 8'hff, 8'hff);
    put_write(REG_DDRB, 8'hff);
    put_write(REG_PRB, 8'h10);
    put_write(REG_CRA, 8'h91);
    put_write(REG_TA_HI, 8'h12);
    put_write(REG_TB_LO, 8'h34);
    put_write(REG_TB_HI, 8'hff);
    put_write(REG_ICR, 8'h8c);
    put_write(REG_SDR, 8'ha5);
    put_read(REG_ICR, 8'hff, 8'hff);
    put_write(REG_TOD_HR, 8'h11);
    put_write(REG_TOD_MN, 8'h59);
    put_write(REG_TOD_SC, 8'h59);
    put_write(REG_TOD_TN, 8'h09);
    put_tick();
    put_read(REG_TOD_HR, 8'hff, 8'hff);
    put_write(REG_CRB, 8'h80);
    put_write(REG_TOD_HR, 8'h92);
    put_write(REG_DDRA, 8'hff);
    put_write(REG_PRA, 8'hfe);
    put_key(3'd0, 8'h7f, 8'hfe);
    put_write(REG_DDRB, 8'h00);
    put_read(REG_PRB, 8'hff, 8'hff);
    put_read(REG_PRA, 8'h00, 8'hff);
    put_write(REG_ICR, 8'h1f);

    // let the directed part settle before the random traffic
    hold_for_drain = 1'b1;
    while (words_to_send.size() < RANDOM_WORDS) begin
      if (!mid_drain_done && words_to_send.size() > RANDOM_WORDS / 2) begin
        hold_for_drain = 1'b1;
        mid_drain_done = 1'b1;
      end
      k = $urandom_range(0, 99);
      if (k < 45) begin
        case ($urandom_range(0, 3))
          0:       put_read(reg_addr_t'(4'($urandom)), rand_lines(), rand_lines());
          1:       put_write(reg_addr_t'(4'($urandom)), 8'($urandom));
          2:       put_tick();
          default: put_key(3'($urandom), rand_lines(), rand_lines());
        endcase
      end else if (k < 60) begin
        // set the clock near a rollover, then let it run
        put_write(REG_CRB, 8'($urandom) & 8'h7f);
        put_write(REG_CRA, 8'($urandom));
        put_write(REG_TOD_HR, rand_hour());
        put_write(REG_TOD_MN, ($urandom_range(0, 3) != 0) ? 8'h59 : 8'($urandom));
        put_write(REG_TOD_SC, ($urandom_range(0, 3) != 0) ? 8'h59 : 8'($urandom));
        put_write(REG_TOD_TN, ($urandom_range(0, 3) != 0) ?
                  8'($urandom_range(7, 9)) : 8'($urandom));
        repeat ($urandom_range(4, 16)) begin
          put_tick();
          if ($urandom_range(0, 3) == 0)
            put_read(reg_addr_t'({2'b10, 2'($urandom)}), 8'hff, 8'hff);
        end
        put_read(REG_TOD_TN, 8'hff, 8'hff);
        put_read(REG_TOD_SC, 8'hff, 8'hff);
        put_read(REG_TOD_MN, 8'hff, 8'hff);
        put_read(REG_TOD_HR, 8'hff, 8'hff);
      end else if (k < 70) begin
        // alarm one tenth ahead of the clock
        hr = rand_hour();
        mn = rand_bcd60();
        sc = rand_bcd60();
        tn = 4'($urandom_range(0, 8));
        if ($urandom_range(0, 1) == 0) put_write(REG_ICR, 8'h84);
        put_write(REG_CRB, 8'($urandom) | 8'h80);
        put_write(REG_TOD_HR, hr);
        put_write(REG_TOD_MN, mn);
        put_write(REG_TOD_SC, sc);
        put_write(REG_TOD_TN, {4'h0, tn + 4'd1});
        put_write(REG_CRB, 8'($urandom) & 8'h7f);
        put_write(REG_TOD_HR, hr);
        put_write(REG_TOD_MN, mn);
        put_write(REG_TOD_SC, sc);
        put_write(REG_TOD_TN, {4'h0, tn});
        repeat ($urandom_range(6, 14)) put_tick();
        put_read(REG_ICR, 8'hff, 8'hff);
      end else if (k < 80) begin
        // scan the matrix both ways
        repeat ($urandom_range(1, 3)) put_key(3'($urandom), rand_lines(), rand_lines());
        bit_sel = 3'($urandom);
        put_write(REG_DDRA, ($urandom_range(0, 3) != 0) ? 8'hff : 8'($urandom));
        put_write(REG_PRA, ($urandom_range(0, 3) != 0) ? ~(8'h01 << bit_sel) : 8'($urandom));
        put_write(REG_DDRB, ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom));
        put_read(REG_PRB, rand_lines(), rand_lines());
        bit_sel = 3'($urandom);
        put_write(REG_DDRB, 8'hff);
        put_write(REG_PRB, ($urandom_range(0, 3) != 0) ? ~(8'h01 << bit_sel) : 8'($urandom));
        put_write(REG_DDRA, ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom));
        put_read(REG_PRA, rand_lines(), rand_lines());
      end else if (k < 90) begin
        put_write(REG_ICR, {1'($urandom_range(0, 1)), 2'($urandom), 5'($urandom)});
        put_write(REG_SDR, 8'($urandom));
        if ($urandom_range(0, 1) == 0) put_tick();
        put_read(REG_ICR, 8'hff, 8'hff);
      end else begin
        put_write(REG_TA_LO, 8'($urandom));
        put_write(REG_TB_LO, 8'($urandom));
        put_write(REG_CRA, 8'($urandom));
        put_write(REG_CRB, 8'($urandom));
        put_write(REG_TA_HI, 8'($urandom));
        put_write(REG_TB_HI, 8'($urandom));
        put_read(REG_TA_LO, 8'hff, 8'hff);
        put_read(REG_TA_HI, 8'hff, 8'hff);
        put_read(REG_TB_LO, 8'hff, 8'hff);
        put_read(REG_TB_HI, 8'hff, 8'hff);
        put_write($urandom_range(0, 1) ? REG_CRA : REG_CRB, 8'($urandom) | 8'h10);
        put_read($urandom_range(0, 1) ? REG_TA_HI : REG_TB_HI, 8'hff, 8'hff);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (words_to_send.size() != 0 || in_valid) @(posedge clk);
    for (k = 0; k < 4000 && replies_due.size() != 0; k++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (replies_due.size() != 0) begin
      $display("%0d predicted replies never arrived", replies_due.size());
      fail_count = fail_count + replies_due.size();
    end

    $display("covered %0d reads, %0d writes, %0d ticks, %0d key updates; %0d replies checked",
             op_seen[OP_READ], op_seen[OP_WRITE], op_seen[OP_TICK], op_seen[OP_KEY],
             replies_seen);
    $display("alarm matches %0d, hour rollovers %0d, mismatches %0d",
             alarm_hits, hour_rolls, fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("timeout waiting for replies");
    $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
design/cia_regs_pkg.sv
design/complex_interface_adapter_regs.sv
sim/tb_complex_interface_adapter_regs.sv
